/* sv/prc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the polygon rectangle clipper.
package prc_pkg;

    localparam int CW = 16;
    localparam int FB = 4;
    localparam int DIV_STEPS = CW;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int CFG_AW = 2;
    localparam int TDATA_W = ((2 * CW + 7) / 8) * 8;

    localparam logic [CFG_AW-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_TOP    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_RIGHT  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_BOTTOM = 2'd3;

    localparam logic signed [CW-1:0] RST_LEFT   = 16'sd1600;
    localparam logic signed [CW-1:0] RST_TOP    = 16'sd1600;
    localparam logic signed [CW-1:0] RST_RIGHT  = 16'sd3200;
    localparam logic signed [CW-1:0] RST_BOTTOM = 16'sd3200;

    // A word between cells: a vertex, a close marker, or both (input side only).
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 vtx;
        logic                 close;
    } t_tok;

    // Which boundary a cell clips against.
    typedef struct packed {
        logic use_y;
        logic keep_ge;
    } t_side;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_EDGE,
        S_MUL,
        S_DIV,
        S_EMIT_X,
        S_EMIT_C,
        S_CLOSE_CHK,
        S_EMIT_CLOSE
    } t_cell_state;

endpackage

/* sv/prc_cell.sv */
`timescale 1ns / 1ps
// One boundary clipping cell: keeps first and previous vertex, emits kept and crossing vertices and the close marker.
module prc_cell import prc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_side                i_side,
    input  logic signed [CW-1:0] i_bound,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_tok                 i_tok,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_tok                 o_tok
);

    t_cell_state r_state, n_state;

    logic signed [CW-1:0] r_fx, r_fy, r_vx, r_vy;
    logic signed [CW-1:0] r_px, r_py, r_cx, r_cy;
    logic                 r_has_first, r_close, r_is_vtx, r_in_close;
    logic                 r_ic;
    logic [CW-1:0]        r_mdb, r_mdn, r_den, r_rem, r_low;
    logic                 r_neg;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_ovalid;
    t_tok                 r_otok;

    logic signed [CW-1:0] w_ap, w_bp, w_ac, w_bc;
    logic                 w_ip, w_ic, w_free, w_load, w_accept;
    logic signed [CW:0]   w_db, w_dn, w_den;
    logic [CW:0]          w_adb, w_adn, w_aden;
    logic [2*CW-1:0]      w_prod;
    logic [CW:0]          w_t, w_tsub;
    logic                 w_ge;
    logic signed [CW:0]   w_cross;
    t_tok                 w_otok;

    assign w_ap = i_side.use_y ? r_py : r_px;
    assign w_bp = i_side.use_y ? r_px : r_py;
    assign w_ac = i_side.use_y ? r_cy : r_cx;
    assign w_bc = i_side.use_y ? r_cx : r_cy;
    assign w_ip = i_side.keep_ge ? (w_ap >= i_bound) : (w_ap <= i_bound);
    assign w_ic = i_side.keep_ge ? (w_ac >= i_bound) : (w_ac <= i_bound);

    assign w_db  = {w_bc[CW-1], w_bc} - {w_bp[CW-1], w_bp};
    assign w_dn  = {i_bound[CW-1], i_bound} - {w_ap[CW-1], w_ap};
    assign w_den = {w_ac[CW-1], w_ac} - {w_ap[CW-1], w_ap};
    assign w_adb  = w_db[CW]  ? (CW+1)'(-w_db)  : (CW+1)'(w_db);
    assign w_adn  = w_dn[CW]  ? (CW+1)'(-w_dn)  : (CW+1)'(w_dn);
    assign w_aden = w_den[CW] ? (CW+1)'(-w_den) : (CW+1)'(w_den);

    assign w_prod = r_mdb * r_mdn;

    // Restoring division step; the remainder stays below the divisor.
    assign w_t    = {r_rem, r_low[CW-1]};
    assign w_ge   = (w_t >= {1'b0, r_den});
    assign w_tsub = w_t - {1'b0, r_den};

    assign w_cross = r_neg ? ({w_bp[CW-1], w_bp} - $signed({1'b0, r_low}))
                           : ({w_bp[CW-1], w_bp} + $signed({1'b0, r_low}));

    assign w_free   = !r_ovalid || i_ready;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_is_vtx && r_has_first) n_state = S_EDGE;
                else n_state = S_CLOSE_CHK;
            end
            S_EDGE: begin
                if (w_ip != w_ic) n_state = S_MUL;
                else if (w_ic) n_state = S_EMIT_C;
                else if (r_in_close) n_state = S_EMIT_CLOSE;
                else n_state = S_CLOSE_CHK;
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_EMIT_X;
            end
            S_EMIT_X: begin
                if (w_free) begin
                    if (r_ic) n_state = S_EMIT_C;
                    else if (r_in_close) n_state = S_EMIT_CLOSE;
                    else n_state = S_CLOSE_CHK;
                end
            end
            S_EMIT_C: begin
                if (w_free) n_state = r_in_close ? S_EMIT_CLOSE : S_CLOSE_CHK;
            end
            S_CLOSE_CHK: begin
                if (r_close && r_has_first) n_state = S_EDGE;
                else if (r_close) n_state = S_EMIT_CLOSE;
                else n_state = S_IDLE;
            end
            S_EMIT_CLOSE: begin
                if (w_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE);
        w_load  = 1'b0;
        w_otok  = '0;
        case (r_state)
            S_EMIT_X: begin
                w_load     = w_free;
                w_otok.vtx = 1'b1;
                w_otok.x   = i_side.use_y ? w_cross[CW-1:0] : i_bound;
                w_otok.y   = i_side.use_y ? i_bound : w_cross[CW-1:0];
            end
            S_EMIT_C: begin
                w_load     = w_free;
                w_otok.vtx = 1'b1;
                w_otok.x   = r_cx;
                w_otok.y   = r_cy;
            end
            S_EMIT_CLOSE: begin
                w_load       = w_free;
                w_otok.close = 1'b1;
            end
            default: w_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_has_first <= 1'b0;
            r_in_close  <= 1'b0;
            r_ovalid    <= 1'b0;
            r_fx        <= '0;
            r_fy        <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= (r_ovalid && !i_ready) || w_load;
            if (w_load) r_otok <= w_otok;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cx       <= i_tok.x;
                        r_cy       <= i_tok.y;
                        r_is_vtx   <= i_tok.vtx;
                        r_close    <= i_tok.close;
                        r_in_close <= 1'b0;
                    end
                end
                S_EVAL: begin
                    if (r_is_vtx) begin
                        r_vx <= r_cx;
                        r_vy <= r_cy;
                        if (r_has_first) begin
                            r_px <= r_vx;
                            r_py <= r_vy;
                        end else begin
                            r_fx        <= r_cx;
                            r_fy        <= r_cy;
                            r_has_first <= 1'b1;
                        end
                    end
                end
                S_EDGE: begin
                    r_ic  <= w_ic;
                    r_mdb <= w_adb[CW-1:0];
                    r_mdn <= w_adn[CW-1:0];
                    r_den <= w_aden[CW-1:0];
                    r_neg <= w_db[CW] ^ w_dn[CW] ^ w_den[CW];
                end
                S_MUL: begin
                    r_rem <= w_prod[2*CW-1:CW];
                    r_low <= w_prod[CW-1:0];
                    r_cnt <= '0;
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_tsub[CW-1:0] : w_t[CW-1:0];
                    r_low <= {r_low[CW-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                end
                S_CLOSE_CHK: begin
                    if (r_close && r_has_first) begin
                        r_px        <= r_vx;
                        r_py        <= r_vy;
                        r_cx        <= r_fx;
                        r_cy        <= r_fy;
                        r_has_first <= 1'b0;
                        r_in_close  <= 1'b1;
                    end
                end
                S_EMIT_CLOSE: begin
                    if (w_free) r_in_close <= 1'b0;
                end
                default: r_in_close <= r_in_close;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_tok   = r_otok;

`ifndef NO_ASSERTIONS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0))
        else $error("divide started with a zero denominator");
    a_idle_not_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_in_close)
        else $error("close edge still pending in idle");
    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_otok)))
        else $error("stalled output word was lost");
    a_close_clears_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_CLOSE) |-> !r_has_first)
        else $error("first vertex survived the close");
`endif

endmodule

/* sv/prc_out.sv */
`timescale 1ns / 1ps
// Result stage: holds back one vertex so the final one can carry the last flag.
module prc_out import prc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_tok                 i_tok,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic                 o_last,
    output logic                 o_empty
);

    logic                 r_valid, r_any;
    logic signed [CW-1:0] r_hx, r_hy, r_x, r_y;
    logic                 r_last, r_empty;
    logic                 w_acc, w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    // A vertex with nothing held produces no word.
    assign w_load  = w_acc && (i_tok.vtx ? r_any : 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_any   <= 1'b0;
            r_hx    <= '0;
            r_hy    <= '0;
        end else begin
            r_valid <= (r_valid && !i_ready) || w_load;
            if (w_load) begin
                r_x     <= r_any ? r_hx : '0;
                r_y     <= r_any ? r_hy : '0;
                r_last  <= !i_tok.vtx;
                r_empty <= !i_tok.vtx && !r_any;
            end
            if (w_acc) begin
                if (i_tok.vtx) begin
                    r_hx  <= i_tok.x;
                    r_hy  <= i_tok.y;
                    r_any <= 1'b1;
                end else begin
                    r_any <= 1'b0;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_last  = r_last;
    assign o_empty = r_empty;

endmodule

/* sv/polygon_rect_clipper_core.sv */
`timescale 1ns / 1ps
// Polygon clipper against a rectangular window: four boundary cells in a chain.
//
// Input channel (s_axis): one word per vertex, x in the low half of tdata, y in
// the high half, tlast on the final vertex of a polygon. Output channel (m_axis):
// clipped vertices in the same packing, tlast on the final vertex of the clipped
// polygon, tuser set on the single word sent for a polygon that lies wholly
// outside (coordinates then zero).
// Window registers are written through i_cfg_we / i_cfg_addr / i_cfg_data: left,
// top (smaller y), right, bottom (larger y). The user must write them only while
// the block is idle; the block itself does not enforce this. Each cell takes one
// word at a time. A crossing adds a multiply, a 16-step divide and a step to hand
// the crossing on, and cells work on successive words concurrently.
// The result stage holds back one vertex, so a vertex appears on the output once
// the next one (or the close) arrives.
// Reset clears the window to its default and drops any partial polygon.
// When the receiver stalls, every cell keeps its output word and stops taking
// input once its work is done, so back-pressure reaches s_axis_tready.
module polygon_rect_clipper_core import prc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // vertex_x, vertex_y
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // out_x, out_y
    output logic               m_axis_tlast,
    output logic               m_axis_tuser,   // polygon_empty
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [CW-1:0]      i_cfg_data
);

    logic signed [CW-1:0] r_left, r_top, r_right, r_bottom;
    logic signed [CW-1:0] w_bound [4];
    t_side                w_side  [4];
    logic                 w_valid [5];
    logic                 w_ready [5];
    t_tok                 w_tok   [5];
    logic signed [CW-1:0] w_ox, w_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= RST_LEFT;
            r_top    <= RST_TOP;
            r_right  <= RST_RIGHT;
            r_bottom <= RST_BOTTOM;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LEFT:   r_left   <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data;
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_BOTTOM: r_bottom <= i_cfg_data;
                default:    r_left   <= r_left;
            endcase
        end
    end

    assign w_bound[0] = r_left;
    assign w_bound[1] = r_right;
    assign w_bound[2] = r_bottom;
    assign w_bound[3] = r_top;
    assign w_side[0]  = '{use_y: 1'b0, keep_ge: 1'b1};
    assign w_side[1]  = '{use_y: 1'b0, keep_ge: 1'b0};
    assign w_side[2]  = '{use_y: 1'b1, keep_ge: 1'b0};
    assign w_side[3]  = '{use_y: 1'b1, keep_ge: 1'b1};

    assign w_valid[0]     = s_axis_tvalid;
    assign s_axis_tready  = w_ready[0];
    assign w_tok[0]       = '{x:     s_axis_tdata[CW-1:0],
                              y:     s_axis_tdata[2*CW-1:CW],
                              vtx:   1'b1,
                              close: s_axis_tlast};

    for (genvar g = 0; g < 4; g++) begin : g_cell
        prc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (w_side[g]),
            .i_bound (w_bound[g]),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_tok   (w_tok[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_tok   (w_tok[g+1])
        );
    end

    prc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[4]),
        .o_ready (w_ready[4]),
        .i_tok   (w_tok[4]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_x     (w_ox),
        .o_y     (w_oy),
        .o_last  (m_axis_tlast),
        .o_empty (m_axis_tuser)
    );

    assign m_axis_tdata = TDATA_W'({w_oy, w_ox});

endmodule
